// ----- design/spn_cipher_16_nibble_assert.svh -----
// ----------------------------------------------------------------------------
// spn_cipher_16_nibble assertion macros
// Shared assertion forms for the cipher checker.
// ----------------------------------------------------------------------------
`ifndef SPN_CIPHER_16_NIBBLE_ASSERT_SVH
`define SPN_CIPHER_16_NIBBLE_ASSERT_SVH

// Clocked check that is switched off while reset is asserted.
`define SPN16_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("spn_cipher_16_nibble: assertion failed");

// Clocked check that also holds while reset is asserted.
`define SPN16_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("spn_cipher_16_nibble: reset assertion failed");

`endif

// ----- design/spn16_pkg.sv -----
// ----------------------------------------------------------------------------
// spn16_pkg
// Constants, register indexes and round functions of the 64-bit SPN cipher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spn16_pkg;

	// Block geometry.
	localparam int BLK_W   = 64;
	localparam int NIBBLES = 16;

	// Configuration port geometry.
	localparam int CFG_IDX_W = 8;
	localparam int RCNT_W    = 3;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SBOX_TABLE  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_BASE    = 8'd2;

	// Reset value of the round count.
	localparam logic [RCNT_W-1:0] ROUND_COUNT_RST = 3'd3;

	// Registers beyond the round stages: input register and output register.
	localparam int EXTRA_STAGES = 2;

	// First row of the circulant mix, position 0 at bit 0.
	localparam logic [NIBBLES-1:0] MIX_ROW = 16'b0110_0011_0110_1110;

	typedef logic [BLK_W-1:0] blk_t;

	// Substitution layer: every nibble is looked up in the S-box register.
	function automatic blk_t sub_layer(input blk_t w, input blk_t sbox);
		blk_t out;
		out = '0;
		for (int i = 0; i < NIBBLES; i++) begin
			out[4*i +: 4] = sbox[{w[4*i +: 4], 2'b00} +: 4];
		end
		return out;
	endfunction

	// Circulant mix: output nibble i XORs input nibbles j with row bit (j-i) set.
	function automatic blk_t mix_layer(input blk_t w);
		blk_t       out;
		logic [3:0] acc;
		logic [3:0] pos;
		out = '0;
		for (int i = 0; i < NIBBLES; i++) begin
			acc = '0;
			for (int j = 0; j < NIBBLES; j++) begin
				pos = 4'(j - i);
				if (MIX_ROW[pos]) begin
					acc = acc ^ w[4*j +: 4];
				end
			end
			out[4*i +: 4] = acc;
		end
		return out;
	endfunction

endpackage

// ----- design/spn_cipher_16_nibble.sv -----
// ----------------------------------------------------------------------------
// spn_cipher_16_nibble
// Unrolled 64-bit substitution-permutation cipher, one round per stage.
// ----------------------------------------------------------------------------
//
// Channel   | Handshake                 | Payload
// ----------+---------------------------+---------------------------------
// input     | start, busy (always low)  | plaintext[63:0]
// result    | done (one-cycle strobe)   | ciphertext[63:0]
// config    | cfg_valid, cfg_ready (=1) | cfg_index[7:0], cfg_data[63:0]
//
// One item is taken in every cycle; an item is accepted when start is high.
// The pipeline registers are an input register, one register stage per
// round unit (key XOR, S-box, mix), and the output register.
// Stages past round_count pass the block through unchanged.
// Reset clears all valid bits and loads the configuration reset values.
// The result side has no back-pressure, so the pipeline never stalls.
`timescale 1ns / 1ps

module spn_cipher_16_nibble #(
	parameter int MAX_ROUNDS = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [spn16_pkg::BLK_W-1:0]       plaintext,
	output logic                              done,
	output logic [spn16_pkg::BLK_W-1:0]       ciphertext,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [spn16_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [spn16_pkg::BLK_W-1:0]       cfg_data
);

	// Configuration registers.
	logic [spn16_pkg::RCNT_W-1:0] round_count_q;
	spn16_pkg::blk_t              sbox_table_q;
	spn16_pkg::blk_t              round_key_q [MAX_ROUNDS];

	// Pipeline registers.
	logic                         in_vld_s0;
	spn16_pkg::blk_t              in_blk_s0;
	logic [MAX_ROUNDS-1:0]        rnd_vld_s;
	spn16_pkg::blk_t              rnd_blk_s [MAX_ROUNDS];
	logic                         done_q;
	spn16_pkg::blk_t              ciphertext_q;

	logic                         cfg_we;

	// The pipeline takes an item every cycle and writes are always taken.
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	// Round count and S-box registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_count_q <= spn16_pkg::ROUND_COUNT_RST;
			sbox_table_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == spn16_pkg::REG_ROUND_COUNT) begin
				round_count_q <= cfg_data[spn16_pkg::RCNT_W-1:0];
			end
			if (cfg_index == spn16_pkg::REG_SBOX_TABLE) begin
				sbox_table_q <= cfg_data;
			end
		end
	end

	// Round key registers; keys for rounds this build lacks are dropped.
	for (genvar r = 0; r < MAX_ROUNDS; r++) begin : g_key
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				round_key_q[r] <= '0;
			end else if (cfg_we &&
					cfg_index == spn16_pkg::REG_KEY_BASE + spn16_pkg::CFG_IDX_W'(r)) begin
				round_key_q[r] <= cfg_data;
			end
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s0 <= 1'b0;
		end else begin
			in_vld_s0 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		in_blk_s0 <= plaintext;
	end

	// One round unit per stage; a stage at or past round_count passes through.
	for (genvar k = 0; k < MAX_ROUNDS; k++) begin : g_round
		logic            vld_in;
		spn16_pkg::blk_t blk_in;
		spn16_pkg::blk_t blk_out;

		if (k == 0) begin : g_first
			assign vld_in = in_vld_s0;
			assign blk_in = in_blk_s0;
		end else begin : g_next
			assign vld_in = rnd_vld_s[k-1];
			assign blk_in = rnd_blk_s[k-1];
		end

		always_comb begin
			if (round_count_q > spn16_pkg::RCNT_W'(k)) begin
				blk_out = spn16_pkg::mix_layer(
					spn16_pkg::sub_layer(blk_in ^ round_key_q[k], sbox_table_q));
			end else begin
				blk_out = blk_in;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rnd_vld_s[k] <= 1'b0;
			end else begin
				rnd_vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rnd_blk_s[k] <= blk_out;
		end
	end

	// Output register drives the result strobe for exactly one cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= rnd_vld_s[MAX_ROUNDS-1];
		end
	end

	always_ff @(posedge clk) begin
		ciphertext_q <= rnd_blk_s[MAX_ROUNDS-1];
	end

	assign done       = done_q;
	assign ciphertext = ciphertext_q;

endmodule

// ----- design/spn16_chk.sv -----
// ----------------------------------------------------------------------------
// spn16_chk
// Port-level timing checks of the cipher pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "spn_cipher_16_nibble_assert.svh"

module spn16_chk #(
	parameter int MAX_ROUNDS = 6
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	localparam int LAT = MAX_ROUNDS + spn16_pkg::EXTRA_STAGES;

	// Every accepted item yields its result a fixed latency later.
	`SPN16_ASSERT(a_result_follows, (start && !busy) |-> ##LAT done)

	// No result appears without an item accepted a latency earlier.
	`SPN16_ASSERT(a_no_stray_result, done |-> $past(start && !busy, LAT))

	// Two items in consecutive cycles give two results in consecutive cycles.
	`SPN16_ASSERT(a_back_to_back, (start && !busy) ##1 (start && !busy) |-> ##LAT done)

	// While reset is held, no result strobe is shown.
	`SPN16_ASSERT_RST(a_quiet_in_reset, !arst_n |-> !done)

endmodule

bind spn_cipher_16_nibble spn16_chk #(
	.MAX_ROUNDS(MAX_ROUNDS)
) u_spn16_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench for spn_cipher_16_nibble
// Drives 64-bit blocks through the cipher under many round-count, S-box and
// round-key settings and checks every ciphertext against an independent
// encryption model kept in a small scoreboard class.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import spn16_pkg::*;

// Number of round-key registers and the largest round count that takes effect.
localparam int KEY_COUNT   = 6;
localparam int ROUND_LIMIT = 6;

// Round count after reset.
localparam logic [RCNT_W-1:0] RESET_ROUNDS = 3'd3;

// First register index past the round keys; writes there are ignored.
localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = REG_KEY_BASE + 8'(KEY_COUNT);
localparam logic [CFG_IDX_W-1:0] REG_TOP_INDEX    = 8'hFF;

// Mix row, written from position 0 on the left.
localparam bit [0:15] MIX_TAPS = 16'b0111_0110_1100_0110;

// S-box that maps every nibble to itself.
localparam blk_t SBOX_IDENTITY = 64'hFEDC_BA98_7654_3210;

// Tracks the cipher settings, predicts ciphertexts and checks the results.
class cipher_tracker;
	logic [RCNT_W-1:0] rounds;
	blk_t              sbox;
	blk_t              keys [KEY_COUNT];
	blk_t              pending_ct [$];
	int unsigned       mismatches;
	int unsigned       checked;
	bit [7:0]          rounds_seen;

	function new();
		rounds      = RESET_ROUNDS;
		sbox        = '0;
		for (int k = 0; k < KEY_COUNT; k++) begin
			keys[k] = '0;
		end
		mismatches  = 0;
		checked     = 0;
		rounds_seen = '0;
	endfunction

	// Register write as the cipher sees it: narrow fields keep their low bits.
	function void write_reg(logic [CFG_IDX_W-1:0] index, blk_t data);
		if (index == REG_ROUND_COUNT) begin
			rounds = data[RCNT_W-1:0];
		end else if (index == REG_SBOX_TABLE) begin
			sbox = data;
		end else if (index >= REG_KEY_BASE && index < REG_FIRST_UNUSED) begin
			keys[index - REG_KEY_BASE] = data;
		end
	endfunction

	function logic [3:0] nibble(blk_t w, int i);
		return 4'((w >> (4 * i)) & 64'hF);
	endfunction

	// Full encryption of one block under the current settings.
	function blk_t encrypt_block(blk_t pt);
		blk_t       state;
		blk_t       subbed;
		blk_t       mixed;
		logic [3:0] acc;
		int         n;
		state = pt;
		n = (rounds > ROUND_LIMIT) ? ROUND_LIMIT : int'(rounds);
		for (int r = 0; r < n; r++) begin
			state  = state ^ keys[r];
			subbed = '0;
			for (int i = 0; i < NIBBLES; i++) begin
				subbed |= blk_t'(nibble(sbox, int'(nibble(state, i)))) << (4 * i);
			end
			mixed = '0;
			for (int i = 0; i < NIBBLES; i++) begin
				acc = '0;
				for (int j = 0; j < NIBBLES; j++) begin
					if (MIX_TAPS[(j - i) & 15]) begin
						acc ^= nibble(subbed, j);
					end
				end
				mixed |= blk_t'(acc) << (4 * i);
			end
			state = mixed;
		end
		return state;
	endfunction

	// Queues the expected ciphertext at the tail, in acceptance order.
	function void note_plaintext(blk_t pt);
		rounds_seen[rounds] = 1'b1;
		pending_ct = {pending_ct, encrypt_block(pt)};
	endfunction

	function void report(string what, blk_t exp_ct, blk_t act_ct);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s: expected ciphertext %h, got %h", $time, what, exp_ct,
				act_ct);
		end
	endfunction

	function void check_ciphertext(blk_t ct);
		blk_t exp_ct;
		if (pending_ct.size() == 0) begin
			report("result with no block in flight", 'x, ct);
		end else begin
			exp_ct = pending_ct.pop_front();
			checked++;
			if (ct !== exp_ct) begin
				report("ciphertext mismatch", exp_ct, ct);
			end
		end
	endfunction
endclass

module testbench;

	localparam int ITEM_TOTAL   = 1050;
	localparam int SETTLE_WAIT  = 20;
	localparam int IDLE_PERCENT = 13;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	blk_t                 plaintext;
	logic                 done;
	blk_t                 ciphertext;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	blk_t                 cfg_data;

	cipher_tracker tracker = new();
	int unsigned   sent;
	int unsigned   settings;
	bit            idle_on;

	spn_cipher_16_nibble u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.plaintext  (plaintext),
		.done       (done),
		.ciphertext (ciphertext),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Every strobed ciphertext is checked at the edge that ends its cycle.
	always @(posedge clk) begin
		if (arst_n && done) begin
			tracker.check_ciphertext(ciphertext);
		end
	end

	function automatic blk_t rand64();
		return {$urandom, $urandom};
	endfunction

	// Mostly permutations; otherwise an arbitrary table with repeated entries.
	function automatic blk_t random_sbox();
		logic [3:0] perm [16];
		logic [3:0] tmp;
		int         j;
		blk_t       tab;
		if ($urandom_range(3) == 0) begin
			return rand64();
		end
		for (int k = 0; k < 16; k++) begin
			perm[k] = 4'(k);
		end
		for (int k = 15; k > 0; k--) begin
			j       = $urandom_range(k);
			tmp     = perm[k];
			perm[k] = perm[j];
			perm[j] = tmp;
		end
		tab = '0;
		for (int k = 0; k < 16; k++) begin
			tab |= blk_t'(perm[k]) << (4 * k);
		end
		return tab;
	endfunction

	// Random blocks, with some sparse and some repeated-nibble patterns.
	function automatic blk_t random_block();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 80) begin
			return rand64();
		end else if (pick < 90) begin
			return blk_t'($urandom_range(1, 15)) << (4 * $urandom_range(15));
		end
		return {16{4'($urandom)}};
	endfunction

	// One register write; valid stays up so that writes can follow back to back.
	task automatic put_reg(logic [CFG_IDX_W-1:0] index, blk_t data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(index, data);
	endtask

	task automatic end_config();
		cfg_valid <= 1'b0;
		cfg_data  <= rand64();
		settings++;
	endtask

	// Offers one block and waits until the cipher takes it.
	task automatic encrypt(blk_t pt);
		start     <= 1'b1;
		plaintext <= pt;
		do @(posedge clk); while (busy);
		tracker.note_plaintext(pt);
		sent++;
	endtask

	// Random gap between items when idling is enabled.
	task automatic maybe_pause();
		if (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			start     <= 1'b0;
			plaintext <= rand64();
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic encrypt_gapped(blk_t pt);
		encrypt(pt);
		maybe_pause();
	endtask

	// Waits until every block in flight has come back.
	task automatic drain();
		start <= 1'b0;
		while (tracker.pending_ct.size() != 0) @(posedge clk);
	endtask

	// Round count written with random upper bits that the register drops.
	task automatic put_rounds(logic [RCNT_W-1:0] rc);
		blk_t noise;
		noise = rand64();
		put_reg(REG_ROUND_COUNT, {noise[BLK_W-1:RCNT_W], rc});
	endtask

	task automatic random_settings();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			put_rounds(RCNT_W'($urandom_range(1, ROUND_LIMIT)));
		end else if (pick < 85) begin
			put_rounds('0);
		end else begin
			put_rounds('1);
		end
		if ($urandom_range(1) == 1) begin
			put_reg(REG_SBOX_TABLE, random_sbox());
		end
		for (int k = 0; k < KEY_COUNT; k++) begin
			if ($urandom_range(1) == 1) begin
				put_reg(8'(REG_KEY_BASE + k), rand64());
			end
		end
		if ($urandom_range(9) == 0) begin
			put_reg(8'($urandom_range(REG_FIRST_UNUSED, REG_TOP_INDEX)), rand64());
		end
		end_config();
	endtask

	// Run limit.
	initial begin
		#400_000;
		$display("timeout with %0d blocks still in flight", tracker.pending_ct.size());
		$display("testbench: errors");
		$finish;
	end

	// Stimulus and end of run.
	initial begin
		int unsigned phase_len;
		arst_n    <= 1'b0;
		start     <= 1'b0;
		plaintext <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		sent      = 0;
		settings  = 0;
		idle_on   = 1'b1;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: three rounds with an all-zero S-box and zero keys.
		encrypt_gapped('0);
		encrypt_gapped('1);
		encrypt_gapped(rand64());
		encrypt_gapped(rand64());
		drain();

		// Zero rounds: the ciphertext is the plaintext, keys notwithstanding.
		put_reg(REG_ROUND_COUNT, 64'hFFFF_FFFF_FFFF_FFF8);
		put_reg(REG_SBOX_TABLE, SBOX_IDENTITY);
		for (int k = 0; k < KEY_COUNT; k++) begin
			put_reg(8'(REG_KEY_BASE + k), rand64());
		end
		end_config();
		encrypt_gapped('0);
		encrypt_gapped('1);
		encrypt_gapped({16{4'h5}});
		encrypt_gapped({16{4'hA}});
		drain();

		// A round count of seven saturates at six; writes past the keys are dropped.
		put_reg(REG_ROUND_COUNT, 64'd7);
		put_reg(REG_SBOX_TABLE, random_sbox());
		for (int k = 0; k < KEY_COUNT; k++) begin
			put_reg(8'(REG_KEY_BASE + k), rand64());
		end
		put_reg(REG_FIRST_UNUSED, rand64());
		put_reg(REG_TOP_INDEX, rand64());
		end_config();
		encrypt_gapped('0);
		encrypt_gapped('1);
		encrypt_gapped(64'h0123_4567_89AB_CDEF);
		encrypt_gapped(rand64());
		encrypt_gapped(rand64());
		drain();

		// One round with an all-ones S-box and an all-ones first key.
		put_reg(REG_ROUND_COUNT, 64'd1);
		put_reg(REG_SBOX_TABLE, '1);
		put_reg(REG_KEY_BASE, '1);
		end_config();
		encrypt_gapped('0);
		encrypt_gapped('1);
		encrypt_gapped(rand64());
		drain();

		// Six rounds with identity S-box and zero keys leave only the linear mix.
		put_reg(REG_ROUND_COUNT, 64'd6);
		put_reg(REG_SBOX_TABLE, SBOX_IDENTITY);
		for (int k = 0; k < KEY_COUNT; k++) begin
			put_reg(8'(REG_KEY_BASE + k), '0);
		end
		end_config();
		encrypt_gapped(64'h1);
		encrypt_gapped(64'h8000_0000_0000_0000);
		encrypt_gapped(64'h0000_000F_0000_0000);
		encrypt_gapped(rand64());
		drain();

		// Random part: phases of random settings, the first one with no gaps.
		idle_on = 1'b0;
		phase_len = 200;
		while (sent < ITEM_TOTAL) begin
			random_settings();
			repeat (phase_len) begin
				encrypt_gapped(random_block());
			end
			drain();
			idle_on   = 1'b1;
			phase_len = $urandom_range(40, 120);
		end

		repeat (SETTLE_WAIT) @(posedge clk);
		$display("%0d blocks sent and %0d ciphertexts checked under %0d settings",
			sent, tracker.checked, settings);
		$display("round counts used (bit per count 7..0): %b; %0d mismatches, %0d missing",
			tracker.rounds_seen, tracker.mismatches, tracker.pending_ct.size());
		if (tracker.mismatches == 0 && tracker.pending_ct.size() == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
